// File: rtl/sfla_pkg.sv
// ============================================================================
// sfla_pkg
// Shared types and constants for the subsampled frame luma average block:
// channel weights, field widths, register indexes and the back-end states.
// ============================================================================
package sfla_pkg;

    // Field and state widths
    localparam int STEP_BITS  = 16;
    localparam int BPP_BITS   = 3;
    localparam int SUM_BITS   = 32;
    localparam int BYTE_BITS  = 8;
    localparam int WSUM_BITS  = 48;
    localparam int LUMA_BITS  = 32;
    localparam int PROD_BITS  = 48;
    localparam int QUO_BITS   = 8;
    localparam int QBIT_BITS  = 3;

    // Default width of the whole-pixel counter
    localparam int DEFAULT_PIXEL_COUNT_BITS = 24;

    // Depth of the frame-total queue between the front and back ends
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = 1;
    localparam int QUEUE_CNT_BITS = 2;

    // BT.709 weights in unsigned Q16; they add up to exactly 65536
    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;

    // Register defaults after reset
    localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd1;
    localparam logic [BPP_BITS-1:0]  BPP_RESET  = 3'd4;
    localparam logic [BPP_BITS-1:0]  BPP_MIN    = 3'd3;
    localparam logic [BPP_BITS-1:0]  BPP_MAX    = 3'd4;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_SAMPLE_STEP    = 1'b0,
        REG_BYTES_IN_PIXEL = 1'b1
    } cfg_index_t;

    // Byte positions within a pixel
    typedef enum logic [1:0] {
        POS_BLUE  = 2'd0,
        POS_GREEN = 2'd1,
        POS_RED   = 2'd2,
        POS_PAD   = 2'd3
    } byte_pos_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE  = 3'd0,
        BK_WEIGH = 3'd1,
        BK_SUM   = 3'd2,
        BK_SCALE = 3'd3,
        BK_CHECK = 3'd4,
        BK_DIV   = 3'd5,
        BK_DONE  = 3'd6
    } back_state_t;

endpackage

// File: rtl/sfla_front.sv
// ============================================================================
// sfla_front
// Accepts frame bytes one per cycle while the queue is not full, sorts them
// into channels, keeps the sampled channel sums and pixel count, and pushes
// the frame totals into the queue on the last byte. Also holds the registers.
// ============================================================================
module sfla_front #(
    parameter int PIXEL_COUNT_BITS = sfla_pkg::DEFAULT_PIXEL_COUNT_BITS,
    parameter int REC_BITS = 3 * sfla_pkg::SUM_BITS + PIXEL_COUNT_BITS + sfla_pkg::STEP_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  sfla_pkg::cfg_index_t          cfg_addr,
    input  logic [sfla_pkg::STEP_BITS-1:0] cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sfla_pkg::BYTE_BITS-1:0] in_byte,
    input  logic                          in_last,
    input  logic                          queue_full,
    output logic                          push,
    output logic [REC_BITS-1:0]           push_data
);
    import sfla_pkg::*;

    logic [STEP_BITS-1:0]        step_cfg_reg;
    logic [BPP_BITS-1:0]         bpp_cfg_reg;
    byte_pos_t                   pos_reg,   pos_next;
    logic [PIXEL_COUNT_BITS-1:0] count_reg, count_next;
    logic [STEP_BITS-1:0]        skip_reg,  skip_next;
    logic [SUM_BITS-1:0]         blue_reg,  blue_next;
    logic [SUM_BITS-1:0]         green_reg, green_next;
    logic [SUM_BITS-1:0]         red_reg,   red_next;

    logic                        accept;
    logic [STEP_BITS-1:0]        step_eff;
    logic [BPP_BITS-1:0]         bpp_eff;
    logic                        sampled;
    logic [BPP_BITS-1:0]         pos_plus;
    logic                        pixel_end;
    logic [SUM_BITS:0]           blue_add, green_add, red_add;

    // Bytes are taken whenever the queue can hold a frame total
    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cfg_reg <= STEP_RESET;
            bpp_cfg_reg  <= BPP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SAMPLE_STEP:    step_cfg_reg <= cfg_wdata;
                REG_BYTES_IN_PIXEL: bpp_cfg_reg  <= cfg_wdata[BPP_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Effective step and pixel size; out-of-range values are clamped
    always_comb
    begin
        step_eff = (step_cfg_reg == '0) ? STEP_BITS'(1) : step_cfg_reg;
        if (bpp_cfg_reg < BPP_MIN)
            bpp_eff = BPP_MIN;
        else if (bpp_cfg_reg > BPP_MAX)
            bpp_eff = BPP_MAX;
        else
            bpp_eff = bpp_cfg_reg;
    end

    // Saturating channel adders
    assign blue_add  = {1'b0, blue_reg}  + (SUM_BITS+1)'(in_byte);
    assign green_add = {1'b0, green_reg} + (SUM_BITS+1)'(in_byte);
    assign red_add   = {1'b0, red_reg}   + (SUM_BITS+1)'(in_byte);

    // Next-state logic for the frame accumulators
    always_comb
    begin
        sampled    = (skip_reg == '0);
        pos_plus   = {1'b0, pos_reg} + BPP_BITS'(1);
        pixel_end  = (pos_plus >= bpp_eff);

        pos_next   = pos_reg;
        count_next = count_reg;
        skip_next  = skip_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        red_next   = red_reg;

        if (accept)
        begin
            if (sampled)
            begin
                unique case (pos_reg)
                    POS_BLUE:  blue_next  = blue_add[SUM_BITS]  ? '1 : blue_add[SUM_BITS-1:0];
                    POS_GREEN: green_next = green_add[SUM_BITS] ? '1 : green_add[SUM_BITS-1:0];
                    POS_RED:   red_next   = red_add[SUM_BITS]   ? '1 : red_add[SUM_BITS-1:0];
                    default:   ;
                endcase
            end
            if (pixel_end)
            begin
                pos_next = POS_BLUE;
                if (count_reg != '1)
                    count_next = count_reg + PIXEL_COUNT_BITS'(1);
                skip_next = sampled ? (step_eff - STEP_BITS'(1)) : (skip_reg - STEP_BITS'(1));
            end
            else
            begin
                pos_next = byte_pos_t'(pos_plus[1:0]);
            end
        end

        // Frame totals include the last byte itself
        push      = accept && in_last;
        push_data = {step_eff, count_next, red_next, green_next, blue_next};

        // The last byte starts a fresh frame
        if (push)
        begin
            pos_next   = POS_BLUE;
            count_next = '0;
            skip_next  = '0;
            blue_next  = '0;
            green_next = '0;
            red_next   = '0;
        end
    end

    // Accumulator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_BLUE;
            count_reg <= '0;
            skip_reg  <= '0;
            blue_reg  <= '0;
            green_reg <= '0;
            red_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
            skip_reg  <= skip_next;
            blue_reg  <= blue_next;
            green_reg <= green_next;
            red_reg   <= red_next;
        end
    end

    // A frame total is never pushed into a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
        else $error("frame total pushed while the queue is full");

    // The last byte leaves a cleared frame behind
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> (pos_reg == POS_BLUE && count_reg == '0 && skip_reg == '0
                                 && blue_reg == '0 && green_reg == '0 && red_reg == '0))
        else $error("frame state not cleared after the last byte");

    // A completed pixel inside a frame adds one to the count below saturation
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_last && pixel_end && count_reg != '1)
            |=> (count_reg == $past(count_reg) + PIXEL_COUNT_BITS'(1)))
        else $error("pixel count did not advance at the end of a pixel");

endmodule

// File: rtl/sfla_queue.sv
// ============================================================================
// sfla_queue
// Short queue of frame totals between the byte front end and the arithmetic
// back end, so that each side can stall on its own.
// ============================================================================
module sfla_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);
    import sfla_pkg::*;

    logic [WIDTH-1:0]          mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wptr_reg, wptr_next;
    logic [QUEUE_PTR_BITS-1:0] rptr_reg, rptr_next;
    logic [QUEUE_CNT_BITS-1:0] cnt_reg,  cnt_next;

    assign full     = (cnt_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign valid    = (cnt_reg != '0);
    assign pop_data = mem[rptr_reg];

    // Pointer and fill-count update
    always_comb
    begin
        wptr_next = push ? wptr_reg + QUEUE_PTR_BITS'(1) : wptr_reg;
        rptr_next = pop  ? rptr_reg + QUEUE_PTR_BITS'(1) : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QUEUE_CNT_BITS'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QUEUE_CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue read while empty");

    a_pointer_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH)) |-> (wptr_reg == rptr_reg))
        else $error("queue pointers disagree with the fill count");

endmodule

// File: rtl/sfla_back.sv
// ============================================================================
// sfla_back
// Turns one frame total into a brightness result: weighs the channel sums,
// scales by the sample step, then divides by the pixel count one quotient
// bit per cycle, saturating at 255. Holds the result in an output register.
// ============================================================================
module sfla_back #(
    parameter int PIXEL_COUNT_BITS = sfla_pkg::DEFAULT_PIXEL_COUNT_BITS,
    parameter int REC_BITS = 3 * sfla_pkg::SUM_BITS + PIXEL_COUNT_BITS + sfla_pkg::STEP_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rec_valid,
    input  logic [REC_BITS-1:0]           rec_data,
    output logic                          rec_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sfla_pkg::QUO_BITS-1:0] out_brightness,
    output logic                          out_empty
);
    import sfla_pkg::*;

    localparam int CNT_LO  = 3 * SUM_BITS;
    localparam int STEP_LO = CNT_LO + PIXEL_COUNT_BITS;
    localparam int PAD8    = PROD_BITS - PIXEL_COUNT_BITS - QUO_BITS;
    localparam int PAD7    = PROD_BITS - PIXEL_COUNT_BITS - (QUO_BITS - 1);

    back_state_t                 st_reg, st_next;
    logic [SUM_BITS-1:0]         blue_reg,  blue_next;
    logic [SUM_BITS-1:0]         green_reg, green_next;
    logic [SUM_BITS-1:0]         red_reg,   red_next;
    logic [PIXEL_COUNT_BITS-1:0] count_reg, count_next;
    logic [STEP_BITS-1:0]        step_reg,  step_next;
    logic [WSUM_BITS-1:0]        wb_reg, wb_next;
    logic [WSUM_BITS-1:0]        wg_reg, wg_next;
    logic [WSUM_BITS-1:0]        wr_reg, wr_next;
    logic [LUMA_BITS-1:0]        luma_reg, luma_next;
    logic [PROD_BITS-1:0]        rem_reg, rem_next;
    logic [PROD_BITS-1:0]        div_reg, div_next;
    logic [QUO_BITS-1:0]         quo_reg, quo_next;
    logic [QBIT_BITS-1:0]        qbit_reg, qbit_next;
    logic                        empty_reg, empty_next;
    logic                        oval_reg, oval_next;
    logic [QUO_BITS-1:0]         obright_reg, obright_next;
    logic                        oempty_reg, oempty_next;
    logic [WSUM_BITS-1:0]        wsum;
    logic [PROD_BITS-1:0]        sat_limit;

    assign wsum      = wb_reg + wg_reg + wr_reg;
    assign sat_limit = {{PAD8{1'b0}}, count_reg, {QUO_BITS{1'b0}}};

    // Sequencer: next state and datapath
    always_comb
    begin
        st_next      = st_reg;
        blue_next    = blue_reg;
        green_next   = green_reg;
        red_next     = red_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        wb_next      = wb_reg;
        wg_next      = wg_reg;
        wr_next      = wr_reg;
        luma_next    = luma_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        quo_next     = quo_reg;
        qbit_next    = qbit_reg;
        empty_next   = empty_reg;
        oval_next    = oval_reg;
        obright_next = obright_reg;
        oempty_next  = oempty_reg;
        rec_pop      = 1'b0;

        // Output register drains independently of the sequencer
        if (oval_reg && out_ready)
            oval_next = 1'b0;

        unique case (st_reg)
            BK_IDLE:
            begin
                if (rec_valid)
                begin
                    rec_pop    = 1'b1;
                    blue_next  = rec_data[SUM_BITS-1:0];
                    green_next = rec_data[2*SUM_BITS-1:SUM_BITS];
                    red_next   = rec_data[CNT_LO-1:2*SUM_BITS];
                    count_next = rec_data[STEP_LO-1:CNT_LO];
                    step_next  = rec_data[REC_BITS-1:STEP_LO];
                    st_next    = BK_WEIGH;
                end
            end
            BK_WEIGH:
            begin
                wb_next = W_BLUE  * blue_reg;
                wg_next = W_GREEN * green_reg;
                wr_next = W_RED   * red_reg;
                st_next = BK_SUM;
            end
            BK_SUM:
            begin
                luma_next = wsum[WSUM_BITS-1:WSUM_BITS-LUMA_BITS];
                st_next   = BK_SCALE;
            end
            BK_SCALE:
            begin
                rem_next = luma_reg * step_reg;
                st_next  = BK_CHECK;
            end
            BK_CHECK:
            begin
                // Empty frames and saturated results skip the division
                if (count_reg == '0)
                begin
                    quo_next   = '0;
                    empty_next = 1'b1;
                    st_next    = BK_DONE;
                end
                else if (rem_reg >= sat_limit)
                begin
                    quo_next   = '1;
                    empty_next = 1'b0;
                    st_next    = BK_DONE;
                end
                else
                begin
                    quo_next   = '0;
                    empty_next = 1'b0;
                    div_next   = {{PAD7{1'b0}}, count_reg, {(QUO_BITS-1){1'b0}}};
                    qbit_next  = QBIT_BITS'(QUO_BITS - 1);
                    st_next    = BK_DIV;
                end
            end
            BK_DIV:
            begin
                // Restoring division, one quotient bit per cycle
                if (rem_reg >= div_reg)
                begin
                    rem_next = rem_reg - div_reg;
                    quo_next = {quo_reg[QUO_BITS-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[QUO_BITS-2:0], 1'b0};
                end
                div_next = div_reg >> 1;
                if (qbit_reg == '0)
                    st_next = BK_DONE;
                else
                    qbit_next = qbit_reg - QBIT_BITS'(1);
            end
            BK_DONE:
            begin
                if (!oval_reg || out_ready)
                begin
                    oval_next    = 1'b1;
                    obright_next = quo_reg;
                    oempty_next  = empty_reg;
                    st_next      = BK_IDLE;
                end
            end
            default:
            begin
                st_next = BK_IDLE;
            end
        endcase
    end

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= BK_IDLE;
            oval_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            oval_reg <= oval_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        blue_reg    <= blue_next;
        green_reg   <= green_next;
        red_reg     <= red_next;
        count_reg   <= count_next;
        step_reg    <= step_next;
        wb_reg      <= wb_next;
        wg_reg      <= wg_next;
        wr_reg      <= wr_next;
        luma_reg    <= luma_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        quo_reg     <= quo_next;
        qbit_reg    <= qbit_next;
        empty_reg   <= empty_next;
        obright_reg <= obright_next;
        oempty_reg  <= oempty_next;
    end

    assign out_valid      = oval_reg;
    assign out_brightness = obright_reg;
    assign out_empty      = oempty_reg;

    // The divider only runs with a nonzero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == BK_DIV) |-> (div_reg != '0))
        else $error("division started with a zero pixel count");

    // An empty frame always reports zero brightness
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_empty) |-> (out_brightness == '0))
        else $error("empty frame with nonzero brightness");

    // The range check leads either to the divider or straight to the result
    a_check_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == BK_CHECK) |=> (st_reg == BK_DIV || st_reg == BK_DONE))
        else $error("unexpected state after the range check");

endmodule

// File: rtl/subsampled_frame_luma_average.sv
// ============================================================================
// subsampled_frame_luma_average
// Weighted BT.709 luma average over every Nth pixel of a byte-stream frame.
// ============================================================================
// Frame bytes are taken one per cycle; s_tready drops only while two frame totals wait.
// A frame total passes the queue, then the back-end states weigh, sum, scale, check,
// divide and done (empty or saturated frames skip divide), one frame total at a time.
// Reset clears the front-end sums and counters, sets sample_step to 1,
// bytes_in_pixel to 4, and empties the queue and the output register.
module subsampled_frame_luma_average #(
    parameter int PIXEL_COUNT_BITS = sfla_pkg::DEFAULT_PIXEL_COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  sfla_pkg::cfg_index_t           cfg_addr,
    input  logic [sfla_pkg::STEP_BITS-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,   // last_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] brightness
    output logic                           m_tuser    // empty_frame
);
    import sfla_pkg::*;

    localparam int REC_BITS = 3 * SUM_BITS + PIXEL_COUNT_BITS + STEP_BITS;

    logic                push;
    logic [REC_BITS-1:0] push_data;
    logic                queue_full;
    logic                rec_pop;
    logic                rec_valid;
    logic [REC_BITS-1:0] rec_data;

    // Byte front end
    sfla_front #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
        .REC_BITS         (REC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // Frame-total queue
    sfla_queue #(
        .WIDTH (REC_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (rec_pop),
        .valid     (rec_valid),
        .pop_data  (rec_data)
    );

    // Arithmetic back end
    sfla_back #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
        .REC_BITS         (REC_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .rec_valid      (rec_valid),
        .rec_data       (rec_data),
        .rec_pop        (rec_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_brightness (m_tdata),
        .out_empty      (m_tuser)
    );

endmodule
